/* sv/binned_path_centroid_builder_assert.svh */
// Assertion macros for the binned path centroid builder.
`ifndef BINNED_PATH_CENTROID_BUILDER_ASSERT_SVH
`define BINNED_PATH_CENTROID_BUILDER_ASSERT_SVH
`ifndef SYNTH
`define BPCB_ASSERT_IMPL(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define BPCB_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) cond |=> prop) else $error(msg);
`else
`define BPCB_ASSERT_IMPL(label, clk, rst_n, prop, msg)
`define BPCB_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg)
`endif
`endif

/* sv/bpcb_pkg.sv */
// Package with types and constants of the binned path centroid builder.
`timescale 1ns / 1ps
`default_nettype none
package bpcb_pkg;
    localparam int MaxPaths  = 8;
    localparam int NumBins   = 8;
    localparam int CountBits = 16;
    localparam int Slots     = MaxPaths * NumBins;
    localparam int SlotBits  = $clog2(Slots);
    localparam int BinBits   = $clog2(NumBins);
    localparam int PathBits  = $clog2(MaxPaths);
    localparam int SumBits   = 40;
    localparam int DataBits  = 24;
    localparam int NumRegs   = 2;
    localparam logic [0:0] RegUnitDistance = 1'b0;
    localparam logic [0:0] RegNumPaths     = 1'b1;
    localparam logic KindVertex = 1'b0;
    localparam logic KindFinish = 1'b1;
    localparam logic StatusJoint = 1'b0;
    localparam logic StatusError = 1'b1;

    typedef struct packed {
        logic        kind;
        logic [3:0]  path_label;
        logic [23:0] root_distance;
        logic signed [23:0] pos_x;
        logic signed [23:0] pos_y;
        logic signed [23:0] pos_z;
    } t_in_item;

    typedef struct packed {
        logic        status;
        logic [2:0]  out_path;
        logic [2:0]  out_bin;
        logic signed [23:0] joint_x;
        logic signed [23:0] joint_y;
        logic signed [23:0] joint_z;
        logic        last;
    } t_out_item;
endpackage
`default_nettype wire

/* sv/bpcb_ram.sv */
// Generic single-port-write, single-read RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none
module bpcb_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  wire                     i_clk,
    input  wire                     i_we,
    input  wire [$clog2(Depth)-1:0] i_waddr,
    input  wire [Width-1:0]         i_wdata,
    input  wire [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]        o_rdata
);
    logic [Width-1:0] r_mem [Depth];
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

/* sv/binned_path_centroid_builder.sv */
// Top level of the binned path centroid builder.
//  channel | ports                           | handshake
//  cfg     | i_cfg_we, i_cfg_idx, i_cfg_data | write at edge when i_cfg_we
//  in      | i_start, i_in                   | taken when i_start and !o_busy
//  out     | o_valid, o_out                  | one cycle per result, receiver cannot stall
// Vertex in range: the shared restoring divider (bin), then S_VRD, S_VWAIT and S_VWR read and
// write back the slot; o_busy holds meanwhile. A vertex with an unused label is dropped at once.
// Finish: S_CHK and S_CHKW check each slot of the active paths; on an empty path one error
// transaction, else per slot S_RDW, S_LOAD and S_EMIT, with the divider run on each axis when not empty.
// Every finish ends with a clearing pass over all 64 slots.
// Reset clears control state and runs the clearing pass over all 64 slots; o_busy holds.
`timescale 1ns / 1ps
`default_nettype none
`include "binned_path_centroid_builder_assert.svh"
module binned_path_centroid_builder
    import bpcb_pkg::*;
(
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_cfg_we,
    input  wire [0:0]  i_cfg_idx,
    input  wire [23:0] i_cfg_data,
    input  wire        i_start,
    input  wire t_in_item i_in,
    output logic       o_busy,
    output logic       o_valid,
    output t_out_item  o_out
);
    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_VDIV, S_VRD, S_VWAIT, S_VWR,
        S_CHK, S_CHKW, S_RD, S_RDW, S_LOAD, S_DIV, S_EMIT
    } t_state;

    t_state r_state;
    logic [23:0] r_unit;
    logic [3:0]  r_np;
    t_in_item    r_item;
    logic [SlotBits-1:0] r_slot;
    logic [SlotBits-1:0] r_last_slot;
    logic [5:0]  r_step;
    logic [1:0]  r_axis;
    logic        r_any;
    logic        r_err;
    // shared divider
    logic [SumBits-1:0] r_quo;
    logic [SumBits:0]   r_rem;
    logic [SumBits-1:0] r_den;
    logic        r_neg;
    logic signed [23:0] r_jx, r_jy, r_jz;

    logic              we;
    logic [SlotBits-1:0] waddr, raddr;
    logic [SumBits-1:0] wx, wy, wz, rx, ry, rz;
    logic [CountBits-1:0] wc, rc;
    logic              n_valid;
    t_out_item         n_out;

    bpcb_ram #(.Width(SumBits), .Depth(Slots)) u_sx (
        .i_clk(i_clk), .i_we(we), .i_waddr(waddr), .i_wdata(wx),
        .i_raddr(raddr), .o_rdata(rx));
    bpcb_ram #(.Width(SumBits), .Depth(Slots)) u_sy (
        .i_clk(i_clk), .i_we(we), .i_waddr(waddr), .i_wdata(wy),
        .i_raddr(raddr), .o_rdata(ry));
    bpcb_ram #(.Width(SumBits), .Depth(Slots)) u_sz (
        .i_clk(i_clk), .i_we(we), .i_waddr(waddr), .i_wdata(wz),
        .i_raddr(raddr), .o_rdata(rz));
    bpcb_ram #(.Width(CountBits), .Depth(Slots)) u_cnt (
        .i_clk(i_clk), .i_we(we), .i_waddr(waddr), .i_wdata(wc),
        .i_raddr(raddr), .o_rdata(rc));

    logic [3:0] act;
    assign act = (r_np > 4'(MaxPaths)) ? 4'(MaxPaths) : r_np;

    logic [SumBits:0] trial;
    assign trial = {r_rem[SumBits-1:0], r_quo[SumBits-1]} - {1'b0, r_den};

    logic [BinBits-1:0] bin;
    assign bin = (r_unit == '0 || r_quo[23:0] > 24'(NumBins - 1)) ?
                 BinBits'(NumBins - 1) : r_quo[BinBits-1:0];

    logic [SumBits-1:0] sel_sum;
    always_comb begin
        case (r_axis)
            2'd0:    sel_sum = rx;
            2'd1:    sel_sum = ry;
            default: sel_sum = rz;
        endcase
    end

    assign raddr = r_slot;
    assign we    = (r_state == S_CLEAR) ||
                   ((r_state == S_VWR) && (rc != {CountBits{1'b1}}));
    assign waddr = r_slot;
    assign wc    = (r_state == S_CLEAR) ? '0 : rc + 1'b1;
    assign wx    = (r_state == S_CLEAR) ? '0 : rx + SumBits'(r_item.pos_x);
    assign wy    = (r_state == S_CLEAR) ? '0 : ry + SumBits'(r_item.pos_y);
    assign wz    = (r_state == S_CLEAR) ? '0 : rz + SumBits'(r_item.pos_z);
    assign o_busy = (r_state != S_IDLE);

    logic [23:0] qs;
    assign qs = r_neg ? 24'(-r_quo) : r_quo[23:0];

    always_comb begin
        n_valid = 1'b0;
        n_out   = '0;
        if (r_state == S_RD && r_err) begin
            n_valid      = 1'b1;
            n_out.status = StatusError;
            n_out.last   = 1'b1;
        end else if (r_state == S_EMIT && rc != '0) begin
            n_valid        = 1'b1;
            n_out.status   = StatusJoint;
            n_out.out_path = 3'(r_slot[SlotBits-1:BinBits]);
            n_out.out_bin  = 3'(r_slot[BinBits-1:0]);
            n_out.joint_x  = r_jx;
            n_out.joint_y  = r_jy;
            n_out.joint_z  = r_jz;
            n_out.last     = (r_slot == r_last_slot);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_unit  <= 24'd256;
            r_np    <= 4'd1;
            r_slot  <= '0;
            o_valid <= 1'b0;
            o_out   <= '0;
        end else begin
            o_valid <= n_valid;
            o_out   <= n_out;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    RegUnitDistance: r_unit <= i_cfg_data;
                    RegNumPaths:     r_np   <= i_cfg_data[3:0];
                    default: ;
                endcase
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_slot <= r_slot + 1'b1;
                    if (r_slot == SlotBits'(Slots - 1)) r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (i_start) begin
                        r_item <= i_in;
                        if (i_in.kind == KindFinish) begin
                            r_slot <= '0; r_any <= 1'b0; r_err <= 1'b0;
                            r_state <= (act == 4'd0) ? S_CLEAR : S_CHK;
                        end else if ({1'b0, i_in.path_label} < {1'b0, act}) begin
                            r_quo <= SumBits'(i_in.root_distance);
                            r_rem <= '0;
                            r_den <= SumBits'(r_unit);
                            r_step <= '0;
                            r_state <= S_VDIV;
                        end
                    end
                end
                S_VDIV: begin
                    r_quo <= {r_quo[SumBits-2:0], ~trial[SumBits]};
                    r_rem <= trial[SumBits] ? {r_rem[SumBits-1:0], r_quo[SumBits-1]}
                                            : trial;
                    r_step <= r_step + 1'b1;
                    if (r_step == 6'(SumBits - 1)) r_state <= S_VRD;
                end
                S_VRD: begin
                    r_slot <= {r_item.path_label[PathBits-1:0], bin};
                    r_state <= S_VWAIT;
                end
                S_VWAIT: r_state <= S_VWR;
                S_VWR: begin
                    r_state <= S_IDLE;
                end
                S_CHK: r_state <= S_CHKW;
                S_CHKW: begin
                    if (rc != '0) r_last_slot <= r_slot;
                    if (r_slot[BinBits-1:0] == BinBits'(NumBins - 1)) begin
                        if (rc == '0 && !r_any) r_err <= 1'b1;
                        r_any <= 1'b0;
                        if ({1'b0, r_slot[SlotBits-1:BinBits]} == act - 4'd1) begin
                            r_slot <= '0;
                            r_state <= S_RD;
                        end else begin
                            r_slot <= r_slot + 1'b1;
                            r_state <= S_CHK;
                        end
                    end else begin
                        if (rc != '0) r_any <= 1'b1;
                        r_slot <= r_slot + 1'b1;
                        r_state <= S_CHK;
                    end
                end
                S_RD: begin
                    if (r_err) begin
                        r_slot <= '0;
                        r_state <= S_CLEAR;
                    end else begin
                        r_axis <= 2'd0;
                        r_state <= S_RDW;
                    end
                end
                S_RDW: r_state <= S_LOAD;
                S_LOAD: begin
                    if (rc == '0) begin
                        r_state <= S_EMIT;
                    end else begin
                        r_neg  <= sel_sum[SumBits-1];
                        r_quo  <= sel_sum[SumBits-1] ? -sel_sum : sel_sum;
                        r_rem  <= '0;
                        r_den  <= SumBits'(rc);
                        r_step <= '0;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (r_step == 6'(SumBits)) begin
                        case (r_axis)
                            2'd0: r_jx <= qs;
                            2'd1: r_jy <= qs;
                            default: r_jz <= qs;
                        endcase
                        r_axis <= r_axis + 1'b1;
                        r_state <= (r_axis == 2'd2) ? S_EMIT : S_LOAD;
                    end else begin
                        r_quo <= {r_quo[SumBits-2:0], ~trial[SumBits]};
                        r_rem <= trial[SumBits] ? {r_rem[SumBits-1:0], r_quo[SumBits-1]}
                                                : trial;
                        r_step <= r_step + 1'b1;
                    end
                end
                S_EMIT: begin
                    r_axis <= 2'd0;
                    if ({1'b0, r_slot} == {act, 3'b000} - 7'd1) begin
                        r_slot <= '0;
                        r_state <= S_CLEAR;
                    end else begin
                        r_slot <= r_slot + 1'b1;
                        r_state <= S_RDW;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    logic finish_taken;
    assign finish_taken = i_start && !o_busy && (i_in.kind == KindFinish);
    logic err_out;
    assign err_out = o_valid && (o_out.status == StatusError);

    `BPCB_ASSERT_NEXT(a_finish_busy, i_clk, i_rst_n, finish_taken, o_busy, "finish not taken")
    `BPCB_ASSERT_IMPL(a_err_last, i_clk, i_rst_n, (!err_out || o_out.last), "error without last")
    `BPCB_ASSERT_NEXT(a_last_gap, i_clk, i_rst_n, (o_valid && o_out.last), !o_valid, "after last")
    `BPCB_ASSERT_IMPL(a_valid_busy, i_clk, i_rst_n, (!o_valid || o_busy), "result while idle")
endmodule
`default_nettype wire

/* tb/binned_path_centroid_builder_test.sv */
// Testbench for the binned path centroid builder: directed table and corner cases, then random checks.
`timescale 1ns / 1ps
`default_nettype none
module binned_path_centroid_builder_test;
    import bpcb_pkg::*;

    localparam int unsigned CountMax = (1 << CountBits) - 1;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [0:0]  cfg_idx;
    logic [23:0] cfg_data;
    logic        start;
    t_in_item    in_item;
    logic        busy;
    logic        valid;
    t_out_item   out_item;

    binned_path_centroid_builder u_dut (
        .i_clk     (clk),
        .i_rst_n   (rst_n),
        .i_cfg_we  (cfg_we),
        .i_cfg_idx (cfg_idx),
        .i_cfg_data(cfg_data),
        .i_start   (start),
        .i_in      (in_item),
        .o_busy    (busy),
        .o_valid   (valid),
        .o_out     (out_item)
    );

    logic [23:0]       unit_dist;
    logic [3:0]        path_count;
    longint            sum_x [Slots];
    longint            sum_y [Slots];
    longint            sum_z [Slots];
    int unsigned       bin_count [Slots];
    t_out_item         joint_queue [$];
    int                mismatches;

    typedef struct {
        t_in_item  item;
        bit        has_joint;
        t_out_item joint;
    } t_row;

    t_row directed [$];

    initial clk = 1'b0;
    always #10 clk = ~clk;

    initial begin
        #200ms;
        $display("binned_path_centroid_builder_test: done, errors");
        $finish;
    end

    function automatic void clear_bins();
        for (int s = 0; s < Slots; s++) begin
            sum_x[s] = 0;
            sum_y[s] = 0;
            sum_z[s] = 0;
            bin_count[s] = 0;
        end
    endfunction

    function automatic void predict_centroids(t_in_item it);
        int unsigned np;
        int unsigned bin;
        int unsigned slot;
        int          n;
        t_out_item   r;
        np = (path_count < MaxPaths) ? path_count : MaxPaths;
        if (it.kind == KindVertex) begin
            if (it.path_label >= np) return;
            if (unit_dist == 0) bin = NumBins - 1;
            else begin
                bin = it.root_distance / unit_dist;
                if (bin > NumBins - 1) bin = NumBins - 1;
            end
            slot = it.path_label * NumBins + bin;
            if (bin_count[slot] >= CountMax) return;
            sum_x[slot] += longint'(it.pos_x);
            sum_y[slot] += longint'(it.pos_y);
            sum_z[slot] += longint'(it.pos_z);
            bin_count[slot]++;
            return;
        end
        for (int p = 0; p < np; p++) begin
            bit any;
            any = 0;
            for (int b = 0; b < NumBins; b++)
                if (bin_count[p * NumBins + b] != 0) any = 1;
            if (!any) begin
                r = '0;
                r.status = StatusError;
                r.last = 1'b1;
                joint_queue = {joint_queue, r};
                clear_bins();
                return;
            end
        end
        n = 0;
        for (int p = 0; p < np; p++) begin
            for (int b = 0; b < NumBins; b++) begin
                slot = p * NumBins + b;
                if (bin_count[slot] == 0) continue;
                r = '0;
                r.status = StatusJoint;
                r.out_path = p[2:0];
                r.out_bin = b[2:0];
                r.joint_x = 24'(sum_x[slot] / longint'(bin_count[slot]));
                r.joint_y = 24'(sum_y[slot] / longint'(bin_count[slot]));
                r.joint_z = 24'(sum_z[slot] / longint'(bin_count[slot]));
                joint_queue = {joint_queue, r};
                n++;
            end
        end
        if (n > 0) joint_queue[$].last = 1'b1;
        clear_bins();
    endfunction

    always @(posedge clk) begin
        if (rst_n && valid) begin
            if (joint_queue.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected joint %p", out_item);
            end else begin
                t_out_item e;
                e = joint_queue.pop_front();
                if (e.status !== out_item.status || e.out_path !== out_item.out_path
                    || e.out_bin !== out_item.out_bin || e.joint_x !== out_item.joint_x
                    || e.joint_y !== out_item.joint_y || e.joint_z !== out_item.joint_z
                    || e.last !== out_item.last) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("joint mismatch: expected %p, got %p", e, out_item);
                end
            end
        end
    end

    task automatic write_reg(logic [0:0] idx, logic [23:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == RegUnitDistance) unit_dist = val;
        else path_count = val[3:0];
    endtask

    task automatic wait_idle();
        while (joint_queue.size() != 0) @(posedge clk);
        repeat (400) @(posedge clk);
    endtask

    function automatic t_in_item noise_item();
        logic [127:0] noise;
        noise = {$urandom, $urandom, $urandom, $urandom};
        return t_in_item'(noise[$bits(t_in_item)-1:0]);
    endfunction

    task automatic send_item(t_in_item it);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
        repeat (gap) @(negedge clk);
        @(negedge clk);
        start <= 1'b1;
        in_item <= it;
        while (busy) @(negedge clk);
        @(posedge clk);
        predict_centroids(it);
        @(negedge clk);
        start <= 1'b0;
        in_item <= noise_item();
    endtask

    function automatic t_in_item vtx(logic [3:0] lbl, logic [23:0] d,
                                     logic [23:0] x, logic [23:0] y, logic [23:0] z);
        t_in_item it;
        it.kind = KindVertex;
        it.path_label = lbl;
        it.root_distance = d;
        it.pos_x = x;
        it.pos_y = y;
        it.pos_z = z;
        return it;
    endfunction

    function automatic t_in_item fin_item();
        t_in_item it;
        it = noise_item();
        it.kind = KindFinish;
        return it;
    endfunction

    function automatic t_in_item rand_vtx(int unsigned np);
        t_in_item it;
        it = noise_item();
        it.kind = KindVertex;
        it.path_label = ($urandom_range(0, 7) == 0) ? 4'($urandom) : 4'($urandom_range(0, np - 1));
        if ($urandom_range(0, 3) != 0)
            it.root_distance = 24'($urandom_range(0, 10 * unit_dist + 1));
        return it;
    endfunction

    function automatic void add_row(t_in_item it, bit has_joint, t_out_item joint);
        t_row row;
        row.item = it;
        row.has_joint = has_joint;
        row.joint = joint;
        directed = {directed, row};
    endfunction

    initial begin
        t_out_item err;
        t_out_item single;
        int        np;
        int        items;
        mismatches = 0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_idx = '0;
        cfg_data = '0;
        start = 1'b0;
        in_item = '0;
        unit_dist = 24'd256;
        path_count = 4'd1;
        clear_bins();
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        err = '0;
        err.status = StatusError;
        err.last = 1'b1;
        single = '0;
        single.status = StatusJoint;
        single.joint_x = 24'h7fffff;
        single.joint_y = 24'h800000;
        single.last = 1'b1;
        add_row(fin_item(), 1'b1, err);
        add_row(vtx(4'd0, 24'd0, 24'h7fffff, 24'h800000, 24'd0), 1'b0, '0);
        add_row(fin_item(), 1'b1, single);
        add_row(vtx(4'd1, 24'd0, 24'd5, 24'd5, 24'd5), 1'b0, '0);
        add_row(vtx(4'd15, 24'd0, 24'd5, 24'd5, 24'd5), 1'b0, '0);
        add_row(fin_item(), 1'b1, err);
        add_row(vtx(4'd0, 24'hffffff, -24'sd3, 24'd3, 24'd1), 1'b0, '0);
        add_row(vtx(4'd0, 24'hffffff, -24'sd4, 24'd4, 24'd0), 1'b0, '0);
        add_row(vtx(4'd0, 24'd255, 24'h7fffff, 24'h800000, 24'h7fffff), 1'b0, '0);
        add_row(vtx(4'd0, 24'd256, 24'h7fffff, 24'h800000, 24'h7fffff), 1'b0, '0);
        add_row(vtx(4'd0, 24'd256, 24'h7fffff, 24'h800000, 24'h800000), 1'b0, '0);
        add_row(fin_item(), 1'b0, '0);

        foreach (directed[i]) begin
            int prior_size;
            prior_size = joint_queue.size();
            send_item(directed[i].item);
            if (directed[i].has_joint) begin
                if (joint_queue.size() != prior_size + 1
                    || joint_queue[$] !== directed[i].joint) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("table row %0d: predictor disagrees with typed joint", i);
                end
            end
        end
        wait_idle();

        write_reg(RegUnitDistance, 24'd0);
        write_reg(RegNumPaths, 24'd8);
        for (int p = 0; p < 8; p++)
            send_item(vtx(p[3:0], 24'($urandom), 24'($urandom), 24'($urandom),
                          24'($urandom)));
        send_item(fin_item());
        wait_idle();
        write_reg(RegNumPaths, 24'd0);
        send_item(vtx(4'd0, 24'd0, 24'd1, 24'd1, 24'd1));
        send_item(fin_item());
        wait_idle();
        write_reg(RegNumPaths, 24'd15);
        write_reg(RegUnitDistance, 24'hffffff);
        send_item(vtx(4'd7, 24'hffffff, 24'd9, 24'd9, 24'd9));
        send_item(vtx(4'd8, 24'd0, 24'd9, 24'd9, 24'd9));
        send_item(fin_item());
        wait_idle();

        items = 0;
        while (items < 100) begin
            int len;
            np = $urandom_range(1, 8);
            if ($urandom_range(0, 5) == 0) write_reg(RegUnitDistance, 24'($urandom_range(1, 24'hffffff)));
            else write_reg(RegUnitDistance, 24'($urandom_range(1, 2048)));
            write_reg(RegNumPaths, 24'(np));
            len = $urandom_range(np, 3 * np + 4);
            for (int k = 0; k < len; k++) begin
                if (k < np && $urandom_range(0, 5) != 0)
                    send_item(vtx(k[3:0], 24'($urandom), 24'($urandom), 24'($urandom),
                                  24'($urandom)));
                else
                    send_item(rand_vtx(np));
                items++;
            end
            send_item(fin_item());
            items++;
            wait_idle();
        end

        if (mismatches == 0 && joint_queue.size() == 0)
            $display("binned_path_centroid_builder_test: done, clean");
        else
            $display("binned_path_centroid_builder_test: done, errors");
        $finish;
    end
endmodule
`default_nettype wire

/* sim.f */
+incdir+sv
sv/bpcb_pkg.sv
sv/bpcb_ram.sv
sv/binned_path_centroid_builder.sv
tb/binned_path_centroid_builder_test.sv
